@@ rtl/multilevel_priority_queue_scheduler_core_defines.svh @@
// ---------------------------------------------------------------------------
// Multilevel priority queue scheduler: assertion macros
// Concurrent assertion wrappers shared by the scheduler modules.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define MULTILEVEL_PRIORITY_QUEUE_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define MLQS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("mlqs assertion failed");
// Check that a condition never holds outside reset.
`define MLQS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("mlqs forbidden condition seen");
`else
`define MLQS_ASSERT(name, clk, rst_n, prop)
`define MLQS_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

@@ rtl/mlqs_pkg.sv @@
// ---------------------------------------------------------------------------
// Multilevel priority queue scheduler package
// Payload types, command/status types, codes and the level mapping.
// ---------------------------------------------------------------------------
package mlqs_pkg;

  localparam int PRIO_FLOOR = 0;
  localparam int PRIO_CEIL  = 10;
  // floor(x / 11) for x <= 100 as (x * 187) >> 11
  localparam int RECIP_MUL    = 187;
  localparam int RECIP_SHIFT  = 11;
  localparam int LEVEL_W      = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVELS  = 2'd0,
    CFG_QUANTUM = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_PICK    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_NONE_READY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [7:0]        task_id;
    logic signed [7:0] priority_req;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_task_id;
    logic [2:0]  out_level;
    logic [15:0] time_slice_ms;
    logic [31:0] total_enqueued;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic deliver;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pick;
  } sts_t;

  // Clamp the priority and map it onto one of nlev levels.
  function automatic logic [LEVEL_W-1:0] level_for(input logic signed [7:0] prio,
                                                   input logic [LEVEL_W-1:0] nlev);
    logic [3:0]  c;
    logic [7:0]  prod;
    logic [15:0] scaled;
    logic [3:0]  lev;
    if (prio < PRIO_FLOOR) begin
      c = 4'(PRIO_FLOOR);
    end else if (prio > PRIO_CEIL) begin
      c = 4'(PRIO_CEIL);
    end else begin
      c = prio[3:0];
    end
    prod   = {4'b0, c} * {4'b0, nlev};
    scaled = {8'b0, prod} * 16'(RECIP_MUL);
    lev    = scaled[RECIP_SHIFT +: 4];
    if (nlev <= 4'd1) begin
      lev = 4'd0;
    end else if (lev > nlev - 4'd1) begin
      lev = nlev - 4'd1;
    end
    return lev;
  endfunction

endpackage

@@ rtl/mlqs_ctrl.sv @@
// ---------------------------------------------------------------------------
// Multilevel priority queue scheduler controller
// Sequences capture, execute and read-back for one request at a time.
// ---------------------------------------------------------------------------
`include "multilevel_priority_queue_scheduler_core_defines.svh"

module mlqs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mlqs_pkg::sts_t sts_i,
  output mlqs_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import mlqs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_pick ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd_o.deliver = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `MLQS_ASSERT(a_exec_after_capture, clk_i, rst_ni,
    (state_q == S_EXEC) |-> $past(state_q == S_IDLE && start_i))
  `MLQS_ASSERT(a_read_after_pick, clk_i, rst_ni,
    (state_q == S_READ) |-> $past(state_q == S_EXEC && sts_i.is_pick))
  `MLQS_ASSERT_NEVER(a_enqueue_no_read, clk_i, rst_ni,
    state_q == S_EXEC && !sts_i.is_pick && state_d == S_READ)

endmodule

@@ rtl/mlqs_dp.sv @@
// ---------------------------------------------------------------------------
// Multilevel priority queue scheduler datapath
// Level FIFOs in one memory, per-level pointers, counters and result register.
// ---------------------------------------------------------------------------
`include "multilevel_priority_queue_scheduler_core_defines.svh"

module mlqs_dp #(
  parameter int MAX_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mlqs_pkg::cmd_t                      cmd_i,
  output mlqs_pkg::sts_t                      sts_o,
  input  mlqs_pkg::req_t                      req_i,
  input  logic                                cfg_we_i,
  input  logic [mlqs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mlqs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                res_valid_o,
  output mlqs_pkg::res_t                      res_o
);
  import mlqs_pkg::*;

  localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = MAX_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // configuration
  logic [LEVEL_W-1:0] levels_q;
  logic [15:0]        quantum_q;
  logic [LEVEL_W-1:0] nlev;

  // captured request
  op_e                op_q;
  logic [7:0]         tid_q;
  logic [LEVEL_W-1:0] lvl_q;

  // per-level queue state
  logic [PTR_W-1:0] head_q [MAX_LEVELS];
  logic [PTR_W-1:0] tail_q [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_q  [MAX_LEVELS];

  logic [31:0] enq_cnt_q, enq_cnt_d;

  logic [7:0]  mem_q [MEM_DEPTH];
  logic [7:0]  rdata_q;

  logic             found, found_q;
  logic [LVL_W-1:0] pick_lvl, pick_lvl_q, sel_lvl;
  logic [PTR_W-1:0] sel_ptr, ptr_next;
  logic [ADDR_W-1:0] addr;
  logic             full, do_write, do_read;

  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= LEVEL_W'(3);
      quantum_q <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVELS:  levels_q  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_QUANTUM: quantum_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (levels_q == '0) begin
      nlev = LEVEL_W'(1);
    end else if (levels_q > LEVEL_W'(MAX_LEVELS)) begin
      nlev = LEVEL_W'(MAX_LEVELS);
    end else begin
      nlev = levels_q;
    end
  end

  // Latch the request and its target level at transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_i.operation;
      tid_q <= req_i.task_id;
      lvl_q <= level_for(req_i.priority_req, nlev);
    end
  end

  assign sts_o.is_pick = (op_q == OP_PICK);

  // Lowest-numbered non-empty level within the active count.
  always_comb begin
    found    = 1'b0;
    pick_lvl = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (!found && (LEVEL_W'(i) < nlev) && (cnt_q[i] != '0)) begin
        found    = 1'b1;
        pick_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    sel_lvl  = (op_q == OP_PICK) ? pick_lvl : lvl_q[LVL_W-1:0];
    sel_ptr  = (op_q == OP_PICK) ? head_q[sel_lvl] : tail_q[sel_lvl];
    ptr_next = (sel_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_ptr + PTR_W'(1);
    addr     = ADDR_W'(sel_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_ptr);
    full     = (cnt_q[sel_lvl] == CNT_W'(QUEUE_DEPTH));
    do_write = cmd_i.exec && (op_q == OP_ENQUEUE) && !full;
    do_read  = cmd_i.exec && (op_q == OP_PICK) && found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      enq_cnt_q <= '0;
    end else begin
      enq_cnt_q <= enq_cnt_d;
      if (do_write) begin
        tail_q[sel_lvl] <= ptr_next;
        cnt_q[sel_lvl]  <= cnt_q[sel_lvl] + CNT_W'(1);
      end else if (do_read) begin
        head_q[sel_lvl] <= ptr_next;
        cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - CNT_W'(1);
      end
    end
  end

  assign enq_cnt_d = do_write ? enq_cnt_q + 32'd1 : enq_cnt_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[addr] <= tid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      found_q    <= found;
      pick_lvl_q <= pick_lvl;
    end
  end

  // Enqueue results are ready after execute; picks after the memory read.
  always_comb begin
    res_d       = res_q;
    res_valid_d = 1'b0;
    if (cmd_i.exec && (op_q == OP_ENQUEUE)) begin
      res_valid_d          = 1'b1;
      res_d.status         = full ? ST_DROPPED : ST_ENQUEUED;
      res_d.out_task_id    = tid_q;
      res_d.out_level      = lvl_q[2:0];
      res_d.time_slice_ms  = '0;
      res_d.total_enqueued = enq_cnt_d;
    end else if (cmd_i.deliver) begin
      res_valid_d          = 1'b1;
      res_d.status         = found_q ? ST_DISPATCHED : ST_NONE_READY;
      res_d.out_task_id    = found_q ? rdata_q : 8'd0;
      res_d.out_level      = found_q ? 3'(pick_lvl_q) : 3'd0;
      res_d.time_slice_ms  = found_q ? quantum_q : 16'd0;
      res_d.total_enqueued = enq_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `MLQS_ASSERT(a_read_nonempty, clk_i, rst_ni,
    do_read |-> (cnt_q[sel_lvl] != '0))
  `MLQS_ASSERT(a_counter_only_on_enqueue, clk_i, rst_ni,
    !$stable(enq_cnt_q) |-> $past(cmd_i.exec && op_q == OP_ENQUEUE))
  `MLQS_ASSERT(a_slice_only_on_dispatch, clk_i, rst_ni,
    (res_valid_q && res_q.status != ST_DISPATCHED) |-> (res_q.time_slice_ms == 16'd0))

endmodule

@@ rtl/multilevel_priority_queue_scheduler_core.sv @@
// ---------------------------------------------------------------------------
// Multilevel priority queue scheduler core
// Strict-priority multilevel FIFO scheduler with enqueue and pick requests.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                                  Transfer when
//  --------  -------------------------------------  -------------------------
//  request   start_i, busy_o, req_i                 start_i high, busy_o low
//  result    res_valid_o, res_o                     res_valid_o high (1 cycle)
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i       cfg_we_i high
//
//  For an enqueue, busy_o is high for the single execute cycle after transfer,
//  and the result strobes in the cycle after execute.
//  For a pick, execute issues the read of the FIFO memory, the registered
//  read data forms the result in the next cycle, and the result strobes in
//  the cycle after that; busy_o is high during execute and read.
//  Reset clears all pointers, fill counts and the enqueue counter at once;
//  the FIFO memory has no clearing pass since only written entries are read.
//  The result side has no back-pressure; every result strobes exactly once.
// ---------------------------------------------------------------------------
module multilevel_priority_queue_scheduler_core #(
  parameter int MAX_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  mlqs_pkg::req_t                  req_i,
  // result channel
  output logic                            res_valid_o,
  output mlqs_pkg::res_t                  res_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [mlqs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mlqs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mlqs_pkg::*;

  // Controller drives the sequence, datapath reports the request kind.
  cmd_t cmd;
  sts_t sts;

  mlqs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold the level queues, the config registers and the result register.
  mlqs_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
